@@ hdl/dilp_pkg.sv @@
// types, codes and helper functions of the decimal integer literal parser
package dilp_pkg;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SKIP   = 2'd1,
        PH_SIGN   = 2'd2,
        PH_DIGITS = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        WM_8  = 2'd0,
        WM_16 = 2'd1,
        WM_32 = 2'd2,
        WM_64 = 2'd3
    } t_width;

    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_NOT_NUMBER     = 3'd1,
        ST_TOO_LARGE      = 3'd2,
        ST_SIGN_UNSIGNED  = 3'd3,
        ST_MISSING_SUFFIX = 3'd4
    } t_status;

    typedef enum logic [0:0] {
        CFG_WIDTH_MODE    = 1'b0,
        CFG_UNSIGNED_MODE = 1'b1
    } t_cfg_idx;

    localparam logic [1:0] WIDTH_MODE_RESET    = 2'd2;
    localparam logic       UNSIGNED_MODE_RESET = 1'b0;

    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_UPPER_L    = 8'h4C;
    localparam logic [7:0] CH_LOWER_L    = 8'h6C;
    localparam logic [7:0] CH_UPPER_U    = 8'h55;
    localparam logic [7:0] CH_LOWER_U    = 8'h75;

    typedef struct packed {
        logic        emit;
        logic [63:0] value;
        t_status     status;
        logic        consumed;
        logic [31:0] line;
    } t_parse_result;

    // largest accumulator that may still take one more digit
    function automatic logic [63:0] digit_limit(input t_width w, input logic uns);
        logic [63:0] lim;
        lim = '0;
        case (w)
            WM_8:    lim = uns ? 64'h18 : 64'hB;
            WM_16:   lim = uns ? 64'h1998 : 64'hCCB;
            WM_32:   lim = uns ? 64'h1999_9998 : 64'hCCC_CCCB;
            WM_64:   lim = uns ? 64'h1999_9999_9999_9998 : 64'h0CCC_CCCC_CCCC_CCCB;
            default: lim = '0;
        endcase
        return lim;
    endfunction

    function automatic logic [63:0] width_mask(input t_width w);
        logic [63:0] m;
        m = '0;
        case (w)
            WM_8:    m = {56'd0, 8'hFF};
            WM_16:   m = {48'd0, 16'hFFFF};
            WM_32:   m = {32'd0, 32'hFFFF_FFFF};
            WM_64:   m = '1;
            default: m = '1;
        endcase
        return m;
    endfunction

endpackage

@@ hdl/dilp_in_if.sv @@
// character word channel of the literal parser
interface dilp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       start_req;

    modport source(output valid, output ch, output start_req, input ready);
    modport sink(input valid, input ch, input start_req, output ready);
endinterface

@@ hdl/dilp_out_if.sv @@
// result word channel of the literal parser
interface dilp_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [2:0]  status;
    logic        consumed_terminator;
    logic [31:0] line_number;

    modport source(output valid, output value, output status,
                   output consumed_terminator, output line_number, input ready);
    modport sink(input valid, input value, input status,
                 input consumed_terminator, input line_number, output ready);
endinterface

@@ hdl/decimal_integer_literal_parser.sv @@
// top level of the decimal integer literal parser
//
//  channel   dir  handshake          payload
//  i_ch      in   valid/ready        ch[7:0], start_req
//  o_res     out  valid/ready        value[63:0], status[2:0], consumed_terminator,
//                                    line_number[31:0]
//  i_cfg_*   in   write enable only  idx[0], data[1:0]
//
// one word per cycle sustained while the result side is not stalled; an accepted word passes
// the input register, then the step logic into the result register
// synchronous active-low reset: width mode 32 bit, signed, parser idle, line count 0
// a stalled result holds the step logic; the input register takes a word only while it is empty
module decimal_integer_literal_parser
    import dilp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    dilp_in_if.sink     i_ch,
    dilp_out_if.source  o_res,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [1:0]  i_cfg_data
);

    logic          r_in_valid;
    logic [7:0]    r_ch;
    logic          r_start;
    logic          r_out_valid;
    t_parse_result r_res;
    t_width        r_width;
    logic          r_unsigned;

    logic          w_adv;
    logic          w_in_ready;
    t_parse_result w_step;

    assign w_adv      = r_in_valid && (!r_out_valid || o_res.ready);
    assign w_in_ready = !r_in_valid || w_adv;
    assign i_ch.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= t_width'(WIDTH_MODE_RESET);
            r_unsigned <= UNSIGNED_MODE_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WIDTH_MODE:    r_width    <= t_width'(i_cfg_data);
                CFG_UNSIGNED_MODE: r_unsigned <= i_cfg_data[0];
                default:           r_unsigned <= r_unsigned;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_ch.valid) begin
            r_ch    <= i_ch.ch;
            r_start <= i_ch.start_req;
        end
    end

    dilp_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_ch       (r_ch),
        .i_start    (r_start),
        .i_width    (r_width),
        .i_unsigned (r_unsigned),
        .o_res      (w_step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_step.emit;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_step.emit) begin
            r_res <= w_step;
        end
    end

    assign o_res.valid               = r_out_valid;
    assign o_res.value               = r_res.value;
    assign o_res.status              = r_res.status;
    assign o_res.consumed_terminator = r_res.consumed;
    assign o_res.line_number         = r_res.line;

    // error results carry a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.status != ST_OK |-> r_res.value == 64'd0)
        else $error("error result with nonzero value");

    // consumed suffix only on a good parse
    a_cons_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.consumed |-> r_res.status == ST_OK)
        else $error("consumed terminator on failed parse");

    // a word in the input register is never dropped while the step stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && $stable(r_ch) && $stable(r_start))
        else $error("input word lost during stall");

endmodule

@@ hdl/dilp_parse.sv @@
// parse state registers and the per-character step logic
module dilp_parse
    import dilp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic [7:0]    i_ch,
    input  logic          i_start,
    input  t_width        i_width,
    input  logic          i_unsigned,
    output t_parse_result o_res
);

    t_phase      r_phase, n_phase;
    logic [63:0] r_acc, n_acc;
    logic        r_neg, n_neg;
    logic        r_us, n_us;
    logic [31:0] r_line, n_line;

    t_phase      w_phase;
    logic [63:0] w_acc;
    logic        w_neg;
    logic        w_us;
    logic        w_digit;
    logic [63:0] w_dval;
    logic [63:0] w_next_acc;
    logic [63:0] w_signed_acc;
    logic        w_suffix_ok;

    assign w_digit      = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign w_dval       = {60'd0, 4'(i_ch - CH_ZERO)};
    assign w_phase      = i_start ? PH_SKIP : r_phase;
    assign w_acc        = i_start ? 64'd0 : r_acc;
    assign w_neg        = i_start ? 1'b0 : r_neg;
    assign w_us         = i_start ? 1'b0 : r_us;
    assign w_next_acc   = (w_acc << 3) + (w_acc << 1) + w_dval;
    assign w_signed_acc = w_neg ? (64'd0 - w_acc) : w_acc;
    assign w_suffix_ok  = i_unsigned ? (i_ch == CH_UPPER_U || i_ch == CH_LOWER_U)
                                     : (i_ch == CH_UPPER_L || i_ch == CH_LOWER_L);

    always_comb begin
        n_phase        = w_phase;
        n_acc          = w_acc;
        n_neg          = w_neg;
        n_us           = w_us;
        n_line         = r_line;
        o_res.emit     = 1'b0;
        o_res.value    = '0;
        o_res.status   = ST_OK;
        o_res.consumed = 1'b0;
        o_res.line     = r_line;
        case (w_phase)
            PH_SKIP: begin
                if (i_ch == CH_SPACE || i_ch == CH_TAB) begin
                    n_phase = PH_SKIP;
                end else if (i_ch == CH_NEWLINE) begin
                    n_line = r_line + 32'd1;
                end else if (i_ch == CH_MINUS) begin
                    if (i_unsigned) begin
                        o_res.emit   = 1'b1;
                        o_res.status = ST_SIGN_UNSIGNED;
                        n_phase      = PH_IDLE;
                    end else begin
                        n_neg   = 1'b1;
                        n_phase = PH_SIGN;
                    end
                end else if (!w_digit) begin
                    o_res.emit   = 1'b1;
                    o_res.status = ST_NOT_NUMBER;
                    n_phase      = PH_IDLE;
                end else begin
                    n_acc   = w_dval;
                    n_phase = PH_DIGITS;
                end
            end
            PH_SIGN: begin
                if (!w_digit) begin
                    o_res.emit   = 1'b1;
                    o_res.status = ST_NOT_NUMBER;
                    n_phase      = PH_IDLE;
                end else begin
                    n_acc   = w_dval;
                    n_phase = PH_DIGITS;
                end
            end
            PH_DIGITS: begin
                if (w_digit) begin
                    if (w_acc > digit_limit(i_width, i_unsigned)) begin
                        o_res.emit   = 1'b1;
                        o_res.status = ST_TOO_LARGE;
                        n_phase      = PH_IDLE;
                    end else begin
                        n_acc = w_next_acc;
                        n_us  = 1'b0;
                    end
                end else if (i_ch == CH_UNDERSCORE && i_width == WM_64 && !w_us) begin
                    n_us = 1'b1;
                end else begin
                    o_res.emit = 1'b1;
                    n_phase    = PH_IDLE;
                    if (i_width == WM_64 && !w_suffix_ok) begin
                        o_res.status = ST_MISSING_SUFFIX;
                    end else begin
                        o_res.value    = w_signed_acc & width_mask(i_width);
                        o_res.consumed = (i_width == WM_64) && i_unsigned;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_us    <= 1'b0;
            r_line  <= '0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_us    <= n_us;
            r_line  <= n_line;
        end
    end

endmodule

@@ bench/decimal_integer_literal_parser_tb.sv @@
// testbench for the decimal integer literal parser: predicted literals checked against dut results
`timescale 1ns / 100ps

module decimal_integer_literal_parser_tb;
    import dilp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int PHASE_WORDS    = 100;

    typedef struct {
        logic [63:0] value;
        t_status     status;
        logic        consumed;
        logic [31:0] line;
    } t_literal;

    class literal_checker;
        t_width      wmode;
        logic        umode;
        t_phase      ph;
        logic [63:0] acc;
        bit          neg;
        bit          usc;
        logic [31:0] line_cnt;
        t_literal    expected_literals[$];
        int          active_words;
        int          checked;
        int          errors;
        int          status_seen[5];
        logic [63:0] ceil_signed[4];
        logic [63:0] ceil_unsigned[4];

        function new();
            wmode         = t_width'(WIDTH_MODE_RESET);
            umode         = UNSIGNED_MODE_RESET;
            ph            = PH_IDLE;
            acc           = '0;
            neg           = 1'b0;
            usc           = 1'b0;
            line_cnt      = '0;
            active_words  = 0;
            checked       = 0;
            errors        = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
            ceil_signed   = '{64'hB, 64'hCCB, 64'hCCC_CCCB, 64'hCCC_CCCC_CCCC_CCCB};
            ceil_unsigned = '{64'h18, 64'h1998, 64'h1999_9998, 64'h1999_9999_9999_9998};
        endfunction

        function void push_literal(logic [63:0] v, t_status st, logic cons);
            t_literal lit;
            lit.value    = v;
            lit.status   = st;
            lit.consumed = cons;
            lit.line     = line_cnt;
            expected_literals.push_back(lit);
            ph = PH_IDLE;
        endfunction

        function void end_literal(logic [7:0] c);
            logic [63:0] v;
            logic [63:0] mask;
            logic        cons;
            cons = 1'b0;
            if (wmode == WM_64) begin
                if (umode) begin
                    if (c != CH_UPPER_U && c != CH_LOWER_U) begin
                        push_literal('0, ST_MISSING_SUFFIX, 1'b0);
                        return;
                    end
                    cons = 1'b1;
                end else if (c != CH_UPPER_L && c != CH_LOWER_L) begin
                    push_literal('0, ST_MISSING_SUFFIX, 1'b0);
                    return;
                end
            end
            v    = neg ? -acc : acc;
            mask = (wmode == WM_64) ? '1 : (64'd1 << (8 << int'(wmode))) - 64'd1;
            push_literal(v & mask, ST_OK, cons);
        endfunction

        function void note_char(logic [7:0] c, logic s);
            bit          digit;
            logic [63:0] d;
            digit = (c >= CH_ZERO) && (c <= CH_NINE);
            d     = {56'd0, c - CH_ZERO};
            if (!s && ph == PH_IDLE) return;
            active_words++;
            if (s) begin
                ph  = PH_SKIP;
                acc = '0;
                neg = 1'b0;
                usc = 1'b0;
            end
            case (ph)
                PH_SKIP: begin
                    if (c == CH_SPACE || c == CH_TAB) return;
                    if (c == CH_NEWLINE) begin
                        line_cnt++;
                        return;
                    end
                    if (c == CH_MINUS) begin
                        if (umode) begin
                            push_literal('0, ST_SIGN_UNSIGNED, 1'b0);
                        end else begin
                            neg = 1'b1;
                            ph  = PH_SIGN;
                        end
                        return;
                    end
                    if (!digit) begin
                        push_literal('0, ST_NOT_NUMBER, 1'b0);
                    end else begin
                        acc = d;
                        ph  = PH_DIGITS;
                    end
                end
                PH_SIGN: begin
                    if (!digit) begin
                        push_literal('0, ST_NOT_NUMBER, 1'b0);
                    end else begin
                        acc = d;
                        ph  = PH_DIGITS;
                    end
                end
                PH_DIGITS: begin
                    if (digit) begin
                        if (acc > (umode ? ceil_unsigned[wmode] : ceil_signed[wmode])) begin
                            push_literal('0, ST_TOO_LARGE, 1'b0);
                        end else begin
                            acc = acc * 10 + d;
                            usc = 1'b0;
                        end
                    end else if (c == CH_UNDERSCORE && wmode == WM_64 && !usc) begin
                        usc = 1'b1;
                    end else begin
                        end_literal(c);
                    end
                end
                default: ph = PH_IDLE;
            endcase
        endfunction

        function void check_literal(logic [63:0] v, logic [2:0] st, logic cons,
                                    logic [31:0] ln);
            t_literal lit;
            checked++;
            if (expected_literals.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result with nothing pending: value=%h status=%0d line=%0d",
                             v, st, ln);
                return;
            end
            lit = expected_literals.pop_front();
            status_seen[lit.status]++;
            if (v !== lit.value || st !== lit.status || cons !== lit.consumed
                    || ln !== lit.line) begin
                errors++;
                if (errors <= 10) begin
                    $display("ERROR: result %0d expected value=%h status=%0d cons=%0b line=%0d,",
                             checked, lit.value, lit.status, lit.consumed, lit.line);
                    $display("       got value=%h status=%0d cons=%0b line=%0d",
                             v, st, cons, ln);
                end
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [0:0] i_cfg_idx;
    logic [1:0] i_cfg_data;

    dilp_in_if  char_if();
    dilp_out_if lit_if();

    literal_checker lits = new();

    bit calm;
    int gap_pct;
    int stall_pct;
    int hold_cnt;
    int quiet_cycles;

    decimal_integer_literal_parser dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ch       (char_if),
        .o_res      (lit_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // result side back-pressure in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt = 0;
            lit_if.ready <= 1'b0;
        end else if (hold_cnt != 0) begin
            lit_if.ready <= (hold_cnt == 1);
            hold_cnt--;
        end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
            lit_if.ready <= 1'b0;
            hold_cnt = $urandom_range(1, 9);
        end else begin
            lit_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && lit_if.valid && lit_if.ready)
            lits.check_literal(lit_if.value, lit_if.status, lit_if.consumed_terminator,
                               lit_if.line_number);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (char_if.valid && char_if.ready)
                || (lit_if.valid && lit_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_char(input logic [7:0] c, input logic s);
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            char_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        char_if.valid     <= 1'b1;
        char_if.ch        <= c;
        char_if.start_req <= s;
        do @(posedge i_clk); while (!char_if.ready);
        lits.note_char(c, s);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_char(txt[i], i == 0);
    endtask

    task automatic settle();
        char_if.valid <= 1'b0;
        while (lits.expected_literals.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(input t_width w, input logic u);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_WIDTH_MODE;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_UNSIGNED_MODE;
        i_cfg_data <= {1'b0, u};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        lits.wmode = w;
        lits.umode = u;
    endtask

    function automatic logic [7:0] any_non_digit();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c >= CH_ZERO && c <= CH_NINE);
        return c;
    endfunction

    task automatic send_random_literal();
        logic [7:0] seq[$];
        int         maxd;
        int         ndig;
        int         roll;
        bit         wide;
        bit         nines;
        wide  = lits.wmode == WM_64;
        nines = $urandom_range(0, 9) == 0;
        maxd  = (lits.wmode == WM_8) ? 3 : (lits.wmode == WM_16) ? 5 :
                (lits.wmode == WM_32) ? 10 : 20;
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                roll = $urandom_range(0, 2);
                seq.push_back(roll == 0 ? CH_SPACE : roll == 1 ? CH_TAB : CH_NEWLINE);
            end
        end
        if ($urandom_range(0, 99) < (lits.umode ? 8 : 30)) begin
            seq.push_back(CH_MINUS);
            if ($urandom_range(0, 19) == 0) seq.push_back(any_non_digit());
        end
        roll = $urandom_range(0, 99);
        if (roll < 15)
            ndig = $urandom_range(1, 2);
        else if (roll < 85)
            ndig = $urandom_range(1, maxd);
        else
            ndig = maxd + $urandom_range(0, 3);
        for (int i = 0; i < ndig; i++) begin
            seq.push_back(CH_ZERO + (nines ? 8'd9 : 8'($urandom_range(0, 9))));
            if (wide && i < ndig - 1 && $urandom_range(0, 99) < 15) begin
                seq.push_back(CH_UNDERSCORE);
                if ($urandom_range(0, 19) == 0) seq.push_back(CH_UNDERSCORE);
            end
        end
        roll = $urandom_range(0, 99);
        if (wide && roll < 80) begin
            if ($urandom_range(0, 19) == 0) seq.push_back(CH_UNDERSCORE);
            // wrong suffix letter now and then
            if (lits.umode ^ (roll >= 70))
                seq.push_back($urandom_range(0, 1) ? CH_UPPER_U : CH_LOWER_U);
            else
                seq.push_back($urandom_range(0, 1) ? CH_UPPER_L : CH_LOWER_L);
        end else if (roll < 95) begin
            seq.push_back(any_non_digit());
        end
        // otherwise left open, the next start drops it
        foreach (seq[i]) send_char(seq[i], i == 0);
    endtask

    task automatic run_phase(input t_width w, input logic u, input int gap, input int stall);
        int goal;
        set_mode(w, u);
        gap_pct   = gap;
        stall_pct = stall;
        goal      = lits.active_words + PHASE_WORDS;
        while (lits.active_words < goal) begin
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3))
                    send_char(8'($urandom), 1'($urandom_range(0, 1)));
            send_random_literal();
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = CFG_WIDTH_MODE;
        i_cfg_data        = '0;
        char_if.valid     = 1'b0;
        char_if.ch        = '0;
        char_if.start_req = 1'b0;
        lit_if.ready      = 1'b0;
        calm              = 1'b0;
        gap_pct           = 30;
        stall_pct         = 30;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset mode: 32 bit signed
        send_char("q", 1'b0);
        send_text(" \t\n-12;");
        send_text("- ");
        send_text("98");
        send_text("7,");
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        set_mode(WM_8, 1'b1);
        send_text("-");
        send_text("300");
        set_mode(WM_64, 1'b0);
        send_text("1_2L");
        send_text("3__");
        set_mode(WM_64, 1'b1);
        send_text("7U");

        run_phase(WM_32, 1'b0, 30, 30);
        run_phase(WM_8, 1'b0, 0, 0);
        run_phase(WM_8, 1'b1, 50, 20);
        run_phase(WM_16, 1'b0, 20, 50);
        run_phase(WM_16, 1'b1, 0, 30);
        run_phase(WM_32, 1'b1, 30, 0);
        run_phase(WM_64, 1'b0, 40, 40);
        run_phase(WM_64, 1'b1, 20, 20);
        calm = 1'b1;
        run_phase(WM_64, 1'b0, 0, 0);
        run_phase(WM_8, 1'b1, 0, 0);
        settle();

        $display("run covered %0d parsed words and %0d literals across all width and sign modes",
                 lits.active_words, lits.checked);
        $display("literal outcomes: ok %0d, not a number %0d, too large %0d, sign %0d, suffix %0d",
                 lits.status_seen[ST_OK], lits.status_seen[ST_NOT_NUMBER],
                 lits.status_seen[ST_TOO_LARGE], lits.status_seen[ST_SIGN_UNSIGNED],
                 lits.status_seen[ST_MISSING_SUFFIX]);
        if (lits.errors == 0 && lits.expected_literals.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches, %0d literals never returned", lits.errors,
                     lits.expected_literals.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ decimal_integer_literal_parser.f @@
hdl/dilp_pkg.sv
hdl/dilp_in_if.sv
hdl/dilp_out_if.sv
hdl/dilp_parse.sv
hdl/decimal_integer_literal_parser.sv
bench/decimal_integer_literal_parser_tb.sv
